>>> design/rssi_trilateration_locator_macros.svh
// Assertion macros for the RSSI trilateration locator.
`ifndef RSSI_TRILATERATION_LOCATOR_MACROS_SVH
`define RSSI_TRILATERATION_LOCATOR_MACROS_SVH

// Check a property outside reset.
`define RSSITL_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property at every edge, reset included.
`define RSSITL_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> design/rssitl_pkg.sv
// Shared types, constants and tables of the RSSI trilateration locator.
`timescale 1ns / 1ps
`default_nettype none
package rssitl_pkg;

    localparam int FRAC_BITS = 8;
    localparam int QW        = 28;

    localparam int DIST_W = 13;
    localparam int POS_W  = 18;
    localparam int ERR_W  = 18;

    localparam logic [DIST_W-1:0] DIST_ONE = DIST_W'(1 << FRAC_BITS);
    localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(20 << FRAC_BITS);
    localparam logic [DIST_W-1:0] DIST_MIN = DIST_W'((3 * (1 << FRAC_BITS) + 5) / 10);

    localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

    localparam logic [1:0] ST_NEW     = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    localparam logic [1:0] REG_TX_ALPHA   = 2'd0;
    localparam logic [1:0] REG_TX_BETA    = 2'd1;
    localparam logic [1:0] REG_TX_CHARLIE = 2'd2;
    localparam logic [1:0] REG_PATH_LOSS  = 2'd3;

    localparam logic [16:0] SCALE_115 = 17'd75366;

    // ceil(2^24 / 3): exact floor divide by three for dividends below 2^23
    localparam logic [22:0] RECIP3 = 23'd5592406;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_RINIT,
        OP_DIV,
        OP_RBIG,
        OP_PMUL,
        OP_PRND,
        OP_TEN,
        OP_SMUL,
        OP_FIN,
        OP_MUL,
        OP_STO,
        OP_POS,
        OP_SQI,
        OP_SQS,
        OP_RES,
        OP_EINIT,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] bcn;
        logic [3:0] idx;
        logic [2:0] sel;
        logic [1:0] kind;
    } cmd_t;

    typedef struct packed {
        logic all_seen;
        logic any_zero;
        logic cur_zero;
        logic cur_special;
        logic big;
    } stat_t;

    typedef logic [15:0][29:0] factor_tab_t;

    function automatic logic [63:0] isqrt_c(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'h1 << 62;
        for (int k = 0; k < 32; k++) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // entry k holds 10^(2^-(k+1)) in Q28
    function automatic factor_tab_t build_factors();
        factor_tab_t t;
        logic [63:0] s;
        s = 64'd10 << QW;
        for (int k = 0; k < 16; k++) begin
            s = isqrt_c(s << QW);
            t[k] = s[29:0];
        end
        return t;
    endfunction

    localparam factor_tab_t POW_FACTOR = build_factors();

endpackage
`default_nettype wire

>>> design/rssitl_ctrl.sv
// Sequencing state machine of the RSSI trilateration locator.
`timescale 1ns / 1ps
`default_nettype none
module rssitl_ctrl (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire                m_tready,
    output rssitl_pkg::cmd_t   cmd,
    input  rssitl_pkg::stat_t  stat
);
    import rssitl_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_CHECK, S_RINIT, S_DIV, S_BIG, S_PMUL, S_PRND, S_TEN, S_SMUL,
        S_FIN, S_ZCHK, S_MUL, S_STO, S_POS, S_SQI, S_SQS, S_RES, S_EINIT,
        S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] bcn_reg, bcn_next;
    logic [2:0] sel_reg, sel_next;
    logic [1:0] kind_reg, kind_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       out_ready;

    assign out_ready = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;

    always_comb begin
        cmd.bcn  = (state_reg == S_MUL) ? sel_reg[1:0] : bcn_reg;
        cmd.idx  = cnt_reg[3:0];
        cmd.sel  = sel_reg;
        cmd.kind = kind_reg;
        unique case (state_reg)
            S_IDLE:  cmd.op = s_tvalid ? OP_LATCH : OP_NONE;
            S_RINIT: cmd.op = OP_RINIT;
            S_DIV:   cmd.op = OP_DIV;
            S_BIG:   cmd.op = OP_RBIG;
            S_PMUL:  cmd.op = OP_PMUL;
            S_PRND:  cmd.op = OP_PRND;
            S_TEN:   cmd.op = OP_TEN;
            S_SMUL:  cmd.op = OP_SMUL;
            S_FIN:   cmd.op = OP_FIN;
            S_MUL:   cmd.op = OP_MUL;
            S_STO:   cmd.op = OP_STO;
            S_POS:   cmd.op = OP_POS;
            S_SQI:   cmd.op = OP_SQI;
            S_SQS:   cmd.op = OP_SQS;
            S_RES:   cmd.op = OP_RES;
            S_EINIT: cmd.op = OP_EINIT;
            S_OUT:   cmd.op = out_ready ? OP_OUT : OP_NONE;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        bcn_next      = bcn_reg;
        sel_next      = sel_reg;
        kind_next     = kind_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_CHECK;
            end
            S_CHECK: begin
                bcn_next = 2'd0;
                if (!stat.all_seen) begin
                    kind_next  = ST_MISSING;
                    state_next = S_OUT;
                end else begin
                    state_next = S_RINIT;
                end
            end
            S_RINIT: begin
                cnt_next = '0;
                if (stat.cur_zero || stat.cur_special) begin
                    bcn_next   = bcn_reg + 2'd1;
                    state_next = (bcn_reg == 2'd2) ? S_ZCHK : S_RINIT;
                end else begin
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd23) state_next = S_BIG;
            end
            S_BIG: begin
                cnt_next = '0;
                if (stat.big) begin
                    bcn_next   = bcn_reg + 2'd1;
                    state_next = (bcn_reg == 2'd2) ? S_ZCHK : S_RINIT;
                end else begin
                    state_next = S_PMUL;
                end
            end
            S_PMUL: state_next = S_PRND;
            S_PRND: begin
                cnt_next   = cnt_reg + 5'd1;
                state_next = (cnt_reg == 5'd15) ? S_TEN : S_PMUL;
            end
            S_TEN:  state_next = S_SMUL;
            S_SMUL: state_next = S_FIN;
            S_FIN: begin
                bcn_next   = bcn_reg + 2'd1;
                state_next = (bcn_reg == 2'd2) ? S_ZCHK : S_RINIT;
            end
            S_ZCHK: begin
                sel_next = '0;
                if (stat.any_zero) begin
                    kind_next  = ST_INVALID;
                    state_next = S_OUT;
                end else begin
                    kind_next  = ST_NEW;
                    state_next = S_MUL;
                end
            end
            S_MUL: state_next = S_STO;
            S_STO: begin
                sel_next = sel_reg + 3'd1;
                bcn_next = 2'd0;
                if (sel_reg == 3'd2) begin
                    state_next = S_POS;
                end else if (sel_reg == 3'd6) begin
                    state_next = S_SQI;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_POS: state_next = S_MUL;
            S_SQI: begin
                cnt_next   = '0;
                state_next = S_SQS;
            end
            S_SQS: begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd18) state_next = S_RES;
            end
            S_RES: begin
                bcn_next   = bcn_reg + 2'd1;
                state_next = (bcn_reg == 2'd2) ? S_EINIT : S_SQI;
            end
            S_EINIT: begin
                cnt_next   = '0;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_ready) begin
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            bcn_reg      <= '0;
            sel_reg      <= '0;
            kind_reg     <= ST_NEW;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            bcn_reg      <= bcn_next;
            sel_reg      <= sel_next;
            kind_reg     <= kind_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule
`default_nettype wire

>>> design/rssitl_dp.sv
// Datapath of the RSSI trilateration locator: ranges, position, residual.
`timescale 1ns / 1ps
`default_nettype none
module rssitl_dp (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                cfg_we,
    input  wire  [1:0]         cfg_index,
    input  wire  [7:0]         cfg_wdata,
    input  wire  [31:0]        s_tdata,
    input  rssitl_pkg::cmd_t   cmd,
    output rssitl_pkg::stat_t  stat,
    output logic [1:0]         m_tuser,
    output logic [95:0]        m_tdata
);
    import rssitl_pkg::*;

    logic [7:0]        tx_reg [3];
    logic [5:0]        plt_reg;
    logic [2:0]        seen_reg;
    logic [7:0]        rssi_reg [3];
    logic [DIST_W-1:0] d_reg [3];
    logic [23:0]       dv_reg;
    logic [6:0]        rem_reg;
    logic [5:0]        den_reg;
    logic [35:0]       r_reg;
    logic [65:0]       prod_reg;
    logic [35:0]       sq_reg [7];
    logic [POS_W-1:0]  x_reg, y_reg;
    logic [36:0]       sv_reg, sr_reg, sb_reg;
    logic [20:0]       acc_reg;
    logic [POS_W-1:0]  held_x_reg, held_y_reg;
    logic [1:0]        o_status_reg;
    logic [POS_W-1:0]  o_x_reg, o_y_reg;
    logic [DIST_W-1:0] o_d_reg [3];
    logic [ERR_W-1:0]  o_err_reg;
    logic [1:0]        o_q_reg;

    logic [7:0]        cur_tx, cur_rssi;
    logic [DIST_W-1:0] cur_d;
    logic [8:0]        diff9;
    logic              ge;
    logic [6:0]        rem_sh;
    logic              q_bit;
    logic [35:0]       mul_a;
    logic [29:0]       mul_b;
    logic [17:0]       ax, ay, axm, aym;
    logic [18:0]       xm, ym;
    logic [63:0]       rnd_sum;
    logic [52:0]       scl_sum;
    logic [35:0]       rr;
    logic [36:0]       fin_sum;
    logic [16:0]       dr;
    logic [DIST_W-1:0] dfin;
    logic [27:0]       vx, vy;
    logic [36:0]       sq_t;
    logic [36:0]       sqi_v;
    logic [18:0]       sroot;
    logic [18:0]       rdiff;
    logic [20:0]       quo;
    logic [ERR_W-1:0]  err;
    logic [1:0]        qual;

    function automatic logic [POS_W-1:0] pos_round(input logic [27:0] v);
        logic [27:0] mag;
        logic [27:0] sum;
        logic [18:0] rm;
        mag = v[27] ? (~v + 28'd1) : v;
        sum = mag + 28'(1 << FRAC_BITS);
        rm  = sum[27:FRAC_BITS+1];
        if (!v[27]) begin
            return (rm > 19'd131071) ? 18'h1FFFF : rm[17:0];
        end
        return (rm > 19'd131072) ? 18'h20000 : (~rm[17:0] + 18'd1);
    endfunction

    assign cur_tx   = tx_reg[cmd.bcn];
    assign cur_rssi = rssi_reg[cmd.bcn];
    assign cur_d    = d_reg[cmd.bcn];
    assign diff9    = {cur_tx[7], cur_tx} - {cur_rssi[7], cur_rssi};
    assign ge       = $signed(cur_rssi) >= $signed(cur_tx);

    assign stat.all_seen    = &seen_reg;
    assign stat.any_zero    = (rssi_reg[0] == 8'd0) || (rssi_reg[1] == 8'd0)
                              || (rssi_reg[2] == 8'd0);
    assign stat.cur_zero    = (cur_rssi == 8'd0);
    assign stat.cur_special = ge || (plt_reg == 6'd0);
    assign stat.big         = |dv_reg[23:17];

    assign rem_sh = {rem_reg[5:0], dv_reg[23]};
    assign q_bit  = (rem_sh >= {1'b0, den_reg});

    assign xm  = {x_reg[17], x_reg} - 19'(1 << FRAC_BITS);
    assign ym  = {y_reg[17], y_reg} - 19'(1 << FRAC_BITS);
    assign ax  = x_reg[17] ? (~x_reg + 18'd1) : x_reg;
    assign ay  = y_reg[17] ? (~y_reg + 18'd1) : y_reg;
    assign axm = xm[18] ? 18'(~xm + 19'd1) : xm[17:0];
    assign aym = ym[18] ? 18'(~ym + 19'd1) : ym[17:0];

    always_comb begin
        mul_a = r_reg;
        mul_b = POW_FACTOR[cmd.idx];
        if (cmd.op == OP_SMUL) begin
            mul_b = 30'(SCALE_115);
        end else if (cmd.op == OP_EINIT) begin
            mul_a = 36'(acc_reg + 21'd1);
            mul_b = 30'(RECIP3);
        end else if (cmd.op == OP_MUL) begin
            case (cmd.sel)
                3'd3:    begin mul_a = 36'(ax);  mul_b = 30'(ax);  end
                3'd4:    begin mul_a = 36'(ay);  mul_b = 30'(ay);  end
                3'd5:    begin mul_a = 36'(axm); mul_b = 30'(axm); end
                3'd6:    begin mul_a = 36'(aym); mul_b = 30'(aym); end
                default: begin mul_a = 36'(cur_d); mul_b = 30'(cur_d); end
            endcase
        end
    end

    assign rnd_sum = prod_reg[63:0] + 64'(1 << (QW - 1));
    assign scl_sum = prod_reg[52:0] + 53'd32768;
    assign rr      = (r_reg > (36'd3 << QW)) ? scl_sum[51:16] : r_reg;
    assign fin_sum = {1'b0, rr} + 37'(1 << (QW - 1 - FRAC_BITS));
    assign dr      = fin_sum[36:QW-FRAC_BITS];
    assign dfin    = (dr > 17'(DIST_MAX)) ? DIST_MAX :
                     (dr < 17'(DIST_MIN)) ? DIST_MIN : dr[DIST_W-1:0];

    assign vx = {3'b0, sq_reg[0][24:0]} - {3'b0, sq_reg[1][24:0]}
                + 28'(1 << (2 * FRAC_BITS));
    assign vy = {3'b0, sq_reg[0][24:0]} - {3'b0, sq_reg[2][24:0]}
                + 28'(1 << (2 * FRAC_BITS));

    assign sq_t = sr_reg + sb_reg;

    always_comb begin
        case (cmd.bcn)
            2'd0:    sqi_v = {1'b0, sq_reg[3]} + {1'b0, sq_reg[4]};
            2'd1:    sqi_v = {1'b0, sq_reg[5]} + {1'b0, sq_reg[4]};
            default: sqi_v = {1'b0, sq_reg[3]} + {1'b0, sq_reg[6]};
        endcase
    end

    assign sroot = sr_reg[18:0];
    assign rdiff = (sroot > 19'(cur_d)) ? (sroot - 19'(cur_d)) : (19'(cur_d) - sroot);

    assign quo  = prod_reg[44:24];
    assign err  = (quo > 21'(ERR_MAX)) ? ERR_MAX : quo[ERR_W-1:0];
    assign qual = (err < ERR_W'(1 << (FRAC_BITS - 1))) ? 2'd0 :
                  (err < ERR_W'(1 << FRAC_BITS))       ? 2'd1 :
                  (err < ERR_W'(2 << FRAC_BITS))       ? 2'd2 : 2'd3;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tx_reg[0]  <= 8'hB5;
            tx_reg[1]  <= 8'hA5;
            tx_reg[2]  <= 8'hB5;
            plt_reg    <= 6'd20;
            held_x_reg <= POS_W'(1 << FRAC_BITS);
            held_y_reg <= POS_W'(1 << FRAC_BITS);
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_TX_ALPHA:   tx_reg[0] <= cfg_wdata;
                    REG_TX_BETA:    tx_reg[1] <= cfg_wdata;
                    REG_TX_CHARLIE: tx_reg[2] <= cfg_wdata;
                    REG_PATH_LOSS:  plt_reg   <= cfg_wdata[5:0];
                    default:        plt_reg   <= plt_reg;
                endcase
            end
            if (cmd.op == OP_OUT && cmd.kind == ST_NEW) begin
                held_x_reg <= x_reg;
                held_y_reg <= y_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LATCH: begin
                seen_reg    <= {s_tdata[18], s_tdata[9], s_tdata[0]};
                rssi_reg[0] <= s_tdata[8:1];
                rssi_reg[1] <= s_tdata[17:10];
                rssi_reg[2] <= s_tdata[26:19];
                d_reg[0]    <= '0;
                d_reg[1]    <= '0;
                d_reg[2]    <= '0;
            end
            OP_RINIT: begin
                if (!stat.cur_zero) begin
                    if (ge) begin
                        d_reg[cmd.bcn] <= DIST_ONE;
                    end else if (plt_reg == 6'd0) begin
                        d_reg[cmd.bcn] <= DIST_MAX;
                    end
                end
                dv_reg  <= {diff9[7:0], 16'd0};
                rem_reg <= '0;
                den_reg <= plt_reg;
            end
            OP_DIV: begin
                dv_reg  <= {dv_reg[22:0], q_bit};
                rem_reg <= q_bit ? (rem_sh - {1'b0, den_reg}) : rem_sh;
            end
            OP_RBIG: begin
                if (stat.big) d_reg[cmd.bcn] <= DIST_MAX;
                r_reg <= 36'd1 << QW;
            end
            OP_PMUL, OP_SMUL, OP_MUL, OP_EINIT: prod_reg <= mul_a * mul_b;
            OP_PRND: begin
                if (dv_reg[4'd15 - cmd.idx]) r_reg <= rnd_sum[63:28];
            end
            OP_TEN: begin
                if (dv_reg[16]) r_reg <= (r_reg << 3) + (r_reg << 1);
            end
            OP_FIN:  d_reg[cmd.bcn] <= dfin;
            OP_STO:  sq_reg[cmd.sel] <= prod_reg[35:0];
            OP_POS: begin
                x_reg <= pos_round(vx);
                y_reg <= pos_round(vy);
            end
            OP_SQI: begin
                sv_reg <= sqi_v;
                sr_reg <= '0;
                sb_reg <= 37'd1 << 36;
                if (cmd.bcn == 2'd0) acc_reg <= '0;
            end
            OP_SQS: begin
                if (sv_reg >= sq_t) begin
                    sv_reg <= sv_reg - sq_t;
                    sr_reg <= (sr_reg >> 1) + sb_reg;
                end else begin
                    sr_reg <= sr_reg >> 1;
                end
                sb_reg <= sb_reg >> 2;
            end
            OP_RES: acc_reg <= acc_reg + 21'(rdiff);
            OP_OUT: begin
                o_status_reg <= cmd.kind;
                o_d_reg[0]   <= d_reg[0];
                o_d_reg[1]   <= d_reg[1];
                o_d_reg[2]   <= d_reg[2];
                if (cmd.kind == ST_NEW) begin
                    o_x_reg   <= x_reg;
                    o_y_reg   <= y_reg;
                    o_err_reg <= err;
                    o_q_reg   <= qual;
                end else begin
                    o_x_reg   <= held_x_reg;
                    o_y_reg   <= held_y_reg;
                    o_err_reg <= '0;
                    o_q_reg   <= 2'd0;
                end
            end
            default: r_reg <= r_reg;
        endcase
    end

    assign m_tuser = o_status_reg;
    assign m_tdata = {1'b0, o_q_reg, o_err_reg, o_d_reg[2], o_d_reg[1], o_d_reg[0],
                      o_y_reg, o_x_reg};

endmodule
`default_nettype wire

>>> design/rssi_trilateration_locator.sv
// Top level of the RSSI trilateration locator.
// One scan in, one result out. A full update with all three beacons runs, per
// beacon, a 24-step exponent divider and a 16-step power-of-ten product through
// one shared multiplier, then a 19-step square root run three times for the
// residual and a reciprocal multiply for the divide by three. Scans with a
// missing beacon go straight to the output. The next scan is taken once the
// current one has been moved to the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "rssi_trilateration_locator_macros.svh"
module rssi_trilateration_locator (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [7:0]  cfg_wdata,
    input  wire         s_tvalid,
    output logic        s_tready,
    // seen_alpha, rssi_alpha, seen_beta, rssi_beta, seen_charlie, rssi_charlie
    input  wire  [31:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // pos_x, pos_y, dist_alpha, dist_beta, dist_charlie, mean_error, quality
    output logic [95:0] m_tdata,
    // status
    output logic [1:0]  m_tuser
);
    import rssitl_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    rssitl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    rssitl_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata)
    );

    `RSSITL_ASSERT(a_busy_after_beat, (s_tvalid && s_tready) |=> !s_tready, "ready after beat")
    `RSSITL_ASSERT(a_status_code, m_tvalid |-> (m_tuser != 2'd3), "bad status code")
    `RSSITL_ASSERT(a_missing_clear, (m_tvalid && m_tuser == ST_MISSING) |-> (m_tdata[94:36] == '0), "missing beacon fields not cleared")
    `RSSITL_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule
`default_nettype wire
